@@ design/stcd_pkg.sv @@
// Shared types and codes for the stopwatch / countdown timer core.
// No dependencies; every other design file imports this package.
`default_nettype none

package stcd_pkg;

   localparam int TIME_WIDTH = 64;
   localparam int KIND_WIDTH = 3;
   localparam int STATE_WIDTH = 2;

   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_TICK     = 3'd0,
      KIND_START    = 3'd1,
      KIND_PAUSE    = 3'd2,
      KIND_CONTINUE = 3'd3,
      KIND_RESET    = 3'd4,
      KIND_LOAD     = 3'd5
   } kind_type;

   typedef enum logic [STATE_WIDTH-1:0] {
      RS_READY   = 2'd0,
      RS_RUNNING = 2'd1,
      RS_LOADED  = 2'd2,
      RS_PAUSED  = 2'd3
   } run_state_type;

   // Timer state as left by the most recent item, handed to the result stage.
   typedef struct packed {
      logic          down;
      run_state_type mode;
      time_type      now_ticks;
      time_type      start_mark;
      time_type      pause_mark;
      time_type      loaded_length;
   } timer_view_type;

endpackage

`default_nettype wire

@@ design/stcd_state.sv @@
// Timer state registers and their update for each accepted item.
// Depends on stcd_pkg.
`default_nettype none

module stcd_state
   import stcd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic                  csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TIME_WIDTH-1:0] req_tdata,
   input  wire logic [KIND_WIDTH-1:0] req_tuser,
   input  wire logic                  take,
   output logic                       pending,
   output timer_view_type             view
);

   logic          down_ff;
   logic          pending_ff, pending_in;
   run_state_type mode_ff, mode_in;
   time_type      now_ff, now_in;
   time_type      start_ff, start_in;
   time_type      pause_ff, pause_in;
   time_type      len_ff, len_in;
   logic          accept;

   // Ready when no item is pending or the pending one is taken in this cycle.
   assign req_tready = !pending_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign pending_in = accept || (pending_ff && !take);

   always_comb begin
      mode_in  = mode_ff;
      now_in   = now_ff;
      start_in = start_ff;
      pause_in = pause_ff;
      len_in   = len_ff;
      if (accept) begin
         unique case (kind_type'(req_tuser))
            KIND_TICK: begin
               now_in = now_ff + TIME_WIDTH'(1);
            end
            KIND_RESET: begin
               start_in = '0;
               pause_in = '0;
               len_in   = '0;
               mode_in  = RS_READY;
            end
            KIND_START: begin
               if ((mode_ff == RS_READY && !down_ff) || (mode_ff == RS_LOADED && down_ff)) begin
                  start_in = now_ff;
                  mode_in  = RS_RUNNING;
               end
            end
            KIND_PAUSE: begin
               if (mode_ff == RS_RUNNING) begin
                  pause_in = now_ff;
                  mode_in  = RS_PAUSED;
               end
            end
            KIND_CONTINUE: begin
               if (mode_ff == RS_PAUSED) begin
                  start_in = start_ff + (now_ff - pause_ff);
                  pause_in = '0;
                  mode_in  = RS_RUNNING;
               end
            end
            KIND_LOAD: begin
               if (mode_ff == RS_READY && down_ff) begin
                  len_in  = req_tdata;
                  mode_in = RS_LOADED;
               end
            end
            default: begin
               // Unassigned codes change nothing but still produce a result.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff    <= 1'b0;
         pending_ff <= 1'b0;
         mode_ff    <= RS_READY;
         now_ff     <= '0;
         start_ff   <= '0;
         pause_ff   <= '0;
         len_ff     <= '0;
      end else begin
         if (csr_wen) begin
            down_ff <= csr_wdata;
         end
         pending_ff <= pending_in;
         mode_ff    <= mode_in;
         now_ff     <= now_in;
         start_ff   <= start_in;
         pause_ff   <= pause_in;
         len_ff     <= len_in;
      end
   end

   assign pending            = pending_ff;
   assign view.down          = down_ff;
   assign view.mode          = mode_ff;
   assign view.now_ticks     = now_ff;
   assign view.start_mark    = start_ff;
   assign view.pause_mark    = pause_ff;
   assign view.loaded_length = len_ff;

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && req_tuser == KIND_TICK |=> now_ff == $past(now_ff) + TIME_WIDTH'(1))
      else $error("tick did not advance the counter");

   a_reset_cmd: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && req_tuser == KIND_RESET |=> mode_ff == RS_READY && len_ff == '0)
      else $error("reset command did not return to ready");

   a_hold_while_waiting: assert property (@(posedge clock) disable iff (reset)
      !reset && pending_ff && !take |=> $stable(now_ff) && $stable(mode_ff) && pending_ff)
      else $error("state moved while a result was still waiting");

endmodule

`default_nettype wire

@@ design/stcd_result.sv @@
// Time value computation and the registered result stage.
// Depends on stcd_pkg.
`default_nettype none

module stcd_result
   import stcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pending,
   input  wire timer_view_type         view,
   output logic                        take,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TIME_WIDTH+7:0]       rsp_tdata
);

   logic          valid_ff, valid_in;
   time_type      time_ff;
   run_state_type state_ff;
   time_type      base;
   time_type      elapsed;
   time_type      over;
   time_type      left;
   time_type      time_value;

   // While paused the pause mark stands in for the counter, so paused time drops out.
   assign base    = (view.mode == RS_PAUSED) ? view.pause_mark : view.now_ticks;
   assign elapsed = base - view.start_mark;
   assign over    = elapsed - view.loaded_length;
   assign left    = view.loaded_length - elapsed;

   always_comb begin
      priority if (view.mode == RS_READY) begin
         time_value = '0;
      end else if (!view.down) begin
         time_value = elapsed;
      end else if (view.mode == RS_LOADED) begin
         time_value = view.loaded_length;
      end else if (over[TIME_WIDTH-1]) begin
         time_value = left;
      end else begin
         time_value = '0;
      end
   end

   assign take     = pending && (!valid_ff || rsp_tready);
   assign valid_in = take || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         time_ff  <= time_value;
         state_ff <= view.mode;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, state_ff, time_ff};

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      !reset && take |=> rsp_tvalid)
      else $error("result not presented after capture");

   a_ready_zero: assert property (@(posedge clock) disable iff (reset)
      !reset && take && view.mode == RS_READY |=> time_ff == '0 && state_ff == RS_READY)
      else $error("ready state must report zero");

   a_countdown_floor: assert property (@(posedge clock) disable iff (reset)
      !reset && take && view.down && view.mode == RS_RUNNING && !over[TIME_WIDTH-1]
      |=> time_ff == '0)
      else $error("expired countdown must report zero");

endmodule

`default_nettype wire

@@ design/stopwatch_countdown_timer_core.sv @@
// Stopwatch / countdown timer core. One item is taken per cycle unless the input stalls,
// and every item, tick or command, gives exactly one result; a full output register only
// stalls the input while the result in it is not taken. The state registers are updated
// at the accepting edge and the time value goes from them into the output register when
// the result stage takes it: a sustained one item per clock while rsp_tready is high.
// The user sets count_down through csr_ only while idle; the block does not enforce it.
// Depends on stcd_pkg, stcd_state and stcd_result.
`default_nettype none

module stopwatch_countdown_timer_core
   import stcd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wen,
   input  wire logic                    csr_wdata,   // count_down
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [TIME_WIDTH-1:0]   req_tdata,   // [63:0] load_value
   input  wire logic [KIND_WIDTH-1:0]   req_tuser,   // [2:0] kind
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [TIME_WIDTH+7:0]        rsp_tdata    // [63:0] time_value, [65:64] run_state
);

   timer_view_type view;
   logic           pending;
   logic           take;

   stcd_state u_state (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .pending    (pending),
      .view       (view)
   );

   stcd_result u_result (
      .clock      (clock),
      .reset      (reset),
      .pending    (pending),
      .view       (view),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
